@@ sv/chm_pkg.sv @@
// shared types and constants for the chained hash map
package chm_pkg;

  localparam int unsigned CFG_W = 10;
  localparam logic [CFG_W-1:0] BUCKETS_RESET = 10'd509;
  localparam int unsigned KEY_W = 32;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned OUT_VALUE_W = 32;
  localparam int unsigned OUT_COUNT_W = 11;

  typedef enum logic [1:0] {
    MODE_GET    = 2'd0,
    MODE_PUT    = 2'd1,
    MODE_REMOVE = 2'd2,
    MODE_SPARE  = 2'd3
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_FOUND     = 2'd0,
    ST_ABSENT    = 2'd1,
    ST_POOL_FULL = 2'd2,
    ST_ZERO_KEY  = 2'd3
  } status_t;

  // request payload
  typedef struct packed {
    mode_t              mode;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
  } chm_req_t;

  // result payload
  typedef struct packed {
    status_t                status;
    logic [OUT_VALUE_W-1:0] old_value;
    logic [OUT_COUNT_W-1:0] entry_count;
  } chm_rsp_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic clr_step;
    logic div_step;
    logic head_rd;
    logic head_wr_new;
    logic head_wr_unlink;
    logic ent_rd;
    logic walk_advance;
    logic put_replace;
    logic put_alloc;
    logic free_rd;
    logic rem_commit;
    logic rem_free_link;
    logic result_load;
    status_t result_status;
    logic result_use_value;
    logic out_load;
  } chm_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic key_zero;
    logic clr_done;
    logic div_done;
    logic cur_end;
    logic prev_end;
    logic key_match;
    logic step_limit;
    logic use_recycled;
    logic use_fresh;
    mode_t mode;
  } chm_sts_t;

endpackage

@@ sv/chm_datapath.sv @@
// hash map datapath: memories, modulo unit, chain walker and pool registers
module chm_datapath import chm_pkg::*; #(
  parameter int unsigned MAX_BUCKETS  = 512,
  parameter int unsigned POOL_ENTRIES = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [CFG_W-1:0]   bucket_count,
  input  logic [1:0]         in_mode,
  input  logic [KEY_W-1:0]   in_key,
  input  logic [VALUE_W-1:0] in_value,
  input  chm_cmd_t           cmd,
  output chm_sts_t           sts,
  output chm_rsp_t           res
);

  localparam int unsigned BW  = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int unsigned PW  = $clog2(POOL_ENTRIES + 1);
  localparam int unsigned IW  = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
  localparam int unsigned MW  = $clog2(MAX_BUCKETS + 1);
  localparam int unsigned DW  = (CFG_W > MW) ? CFG_W : MW;
  localparam int unsigned QW  = KEY_W - 2;
  localparam int unsigned CW  = $clog2(QW + 1);
  localparam logic [PW-1:0] EOC = PW'(POOL_ENTRIES);

  logic [PW-1:0]      heads_mem [MAX_BUCKETS];
  logic [KEY_W-1:0]   keys_mem  [POOL_ENTRIES];
  logic [VALUE_W-1:0] vals_mem  [POOL_ENTRIES];
  logic [PW-1:0]      links_mem [POOL_ENTRIES];

  logic [1:0]            mode_r;
  logic [KEY_W-1:0]      key_r;
  logic [VALUE_W-1:0]    value_r;
  logic [MW-1:0]         div_r;
  logic [QW-1:0]         quo_r;
  logic [MW:0]           rem_r;
  logic [CW-1:0]         dcnt_r;
  logic [BW-1:0]         clr_r;
  logic                  clr_done_r;
  logic [PW-1:0]         cur_r, prev_r, steps_r;
  logic [PW-1:0]         head_q_r;
  logic [KEY_W-1:0]      key_q_r;
  logic [VALUE_W-1:0]    val_q_r;
  logic [PW-1:0]         link_q_r;
  logic [PW-1:0]         free_link_q_r;
  logic [PW-1:0]         free_head_r, fresh_r, count_r;
  status_t               st_r;
  logic [OUT_VALUE_W-1:0] old_r;
  chm_rsp_t              res_r;

  logic [DW-1:0]   eff;
  logic [MW:0]     rem_sh, rem_nxt;
  logic [BW-1:0]   bucket;
  logic [IW-1:0]   cur_i, prev_i, free_i, fresh_i;

  always_comb begin
    if (bucket_count == '0) eff = DW'(1);
    else if (DW'(bucket_count) > DW'(MAX_BUCKETS)) eff = DW'(MAX_BUCKETS);
    else eff = DW'(bucket_count);
  end

  assign rem_sh  = {rem_r[MW-1:0], quo_r[QW-1]};
  assign rem_nxt = (rem_sh >= {1'b0, div_r}) ? rem_sh - {1'b0, div_r} : rem_sh;
  assign bucket  = BW'(rem_r);
  assign cur_i   = IW'(cur_r);
  assign prev_i  = IW'(prev_r);
  assign free_i  = IW'(free_head_r);
  assign fresh_i = IW'(fresh_r);

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
      clr_done_r <= 1'b0;
      free_head_r <= '0;
      fresh_r <= '0;
      count_r <= '0;
      dcnt_r <= '0;
    end else begin
      if (cmd.clr_step) begin
        clr_r <= clr_r + BW'(1);
        if (BW'(clr_r) == BW'(MAX_BUCKETS - 1)) clr_done_r <= 1'b1;
      end
      if (cmd.load) dcnt_r <= CW'(QW);
      else if (cmd.div_step) dcnt_r <= dcnt_r - CW'(1);
      if (cmd.put_alloc) begin
        count_r <= count_r + PW'(1);
        if (count_r < fresh_r) free_head_r <= free_link_q_r;
        else fresh_r <= fresh_r + PW'(1);
      end
      if (cmd.rem_free_link) begin
        free_head_r <= cur_r;
        if (count_r != '0) count_r <= count_r - PW'(1);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r  <= in_mode;
      key_r   <= in_key;
      value_r <= in_value;
      div_r   <= MW'(eff);
      quo_r   <= in_key[KEY_W-1:2];
      rem_r   <= '0;
    end else if (cmd.div_step) begin
      quo_r <= {quo_r[QW-2:0], 1'b0};
      rem_r <= rem_nxt;
    end
    if (cmd.head_rd) begin
      cur_r   <= heads_mem[bucket];
      prev_r  <= EOC;
      steps_r <= '0;
    end
    if (cmd.walk_advance) begin
      prev_r  <= cur_r;
      cur_r   <= link_q_r;
      steps_r <= steps_r + PW'(1);
    end
    if (cmd.ent_rd) begin
      key_q_r  <= keys_mem[cur_i];
      val_q_r  <= vals_mem[cur_i];
      link_q_r <= links_mem[cur_i];
    end
    if (cmd.free_rd) free_link_q_r <= links_mem[free_i];
    if (cmd.head_rd) head_q_r <= heads_mem[bucket];
    if (cmd.result_load) begin
      st_r  <= cmd.result_status;
      old_r <= cmd.result_use_value ? OUT_VALUE_W'(val_q_r) : '0;
    end
    // output register, held while a result waits
    if (cmd.out_load) begin
      res_r <= '{status: st_r, old_value: old_r, entry_count: OUT_COUNT_W'(count_r)};
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (cmd.clr_step) heads_mem[clr_r] <= EOC;
    if (cmd.head_wr_new)
      heads_mem[bucket] <= (count_r < fresh_r) ? free_head_r : fresh_r;
    if (cmd.head_wr_unlink) heads_mem[bucket] <= link_q_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.put_replace) vals_mem[cur_i] <= value_r;
    if (cmd.put_alloc) begin
      if (count_r < fresh_r) begin
        keys_mem[free_i] <= key_r;
        vals_mem[free_i] <= value_r;
      end else begin
        keys_mem[fresh_i] <= key_r;
        vals_mem[fresh_i] <= value_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.put_alloc) begin
      if (count_r < fresh_r) links_mem[free_i] <= head_q_r;
      else links_mem[fresh_i] <= head_q_r;
    end
    if (cmd.rem_commit) links_mem[prev_i] <= link_q_r;
    if (cmd.rem_free_link) links_mem[cur_i] <= free_head_r;
  end

  assign sts.key_zero     = (key_r == '0);
  assign sts.clr_done     = clr_done_r;
  assign sts.div_done     = (dcnt_r == '0);
  assign sts.cur_end      = (cur_r >= EOC);
  assign sts.prev_end     = (prev_r >= EOC);
  assign sts.key_match    = (key_q_r == key_r);
  assign sts.step_limit   = (steps_r >= EOC);
  assign sts.use_recycled = (count_r < fresh_r) && (free_head_r < EOC);
  assign sts.use_fresh    = (count_r >= fresh_r) && (fresh_r < EOC);
  assign sts.mode         = mode_t'(mode_r);

  assign res = res_r;

endmodule

@@ sv/chm_ctrl.sv @@
// hash map controller: sequences hash, chain walk, update and result
module chm_ctrl import chm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  chm_sts_t sts,
  output chm_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DIV, S_HEAD, S_CHECK, S_RDENT, S_MATCH,
    S_ALLOC, S_REMOVE, S_REMFREE, S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    out_valid_nxt = out_valid_r;
    cmd = '0;
    cmd.result_status = ST_ABSENT;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (sts.key_zero) begin
          cmd.result_load = 1'b1;
          cmd.result_status = ST_ZERO_KEY;
          state_nxt = S_OUT;
        end else if (sts.div_done) begin
          state_nxt = S_HEAD;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_HEAD: begin
        cmd.head_rd = 1'b1;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (sts.cur_end || sts.step_limit) begin
          if (sts.mode == MODE_PUT) begin
            cmd.free_rd = 1'b1;
            state_nxt = S_ALLOC;
          end else begin
            cmd.result_load = 1'b1;
            cmd.result_status = ST_ABSENT;
            state_nxt = S_OUT;
          end
        end else begin
          cmd.ent_rd = 1'b1;
          state_nxt = S_MATCH;
        end
      end
      S_MATCH: begin
        if (sts.key_match) begin
          cmd.result_load = 1'b1;
          cmd.result_status = ST_FOUND;
          cmd.result_use_value = 1'b1;
          case (sts.mode)
            MODE_PUT: begin
              cmd.put_replace = 1'b1;
              state_nxt = S_OUT;
            end
            MODE_REMOVE: state_nxt = S_REMOVE;
            default: state_nxt = S_OUT;
          endcase
        end else begin
          cmd.walk_advance = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_ALLOC: begin
        cmd.result_load = 1'b1;
        if (sts.use_recycled || sts.use_fresh) begin
          cmd.put_alloc = 1'b1;
          cmd.head_wr_new = 1'b1;
          cmd.result_status = ST_ABSENT;
        end else begin
          cmd.result_status = ST_POOL_FULL;
        end
        state_nxt = S_OUT;
      end
      S_REMOVE: begin
        if (sts.prev_end) cmd.head_wr_unlink = 1'b1;
        else cmd.rem_commit = 1'b1;
        state_nxt = S_REMFREE;
      end
      S_REMFREE: begin
        cmd.rem_free_link = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

@@ sv/chained_hash_map.sv @@
// top level of the chained hash map
//   channel   direction  handshake               payload
//   in_       input      in_valid / in_ready     chm_req_t (mode, key, value)
//   out_      output     out_valid / out_ready   chm_rsp_t (status, old_value, entry_count)
//   cfg_      input      cfg_we                  cfg_data (bucket_count)
// after reset the chain heads are cleared one bucket at a time, no request taken
// each request runs a bit-serial modulo of the key by the bucket count, then a chain
// walk that reads and compares one entry at a time; an added entry passes an
// allocation step, a removal unlink and free steps; a zero key skips modulo and walk
// a waiting result holds only the output step of the next request; the output
// register lets that request enter while the result waits on out_ready
module chained_hash_map import chm_pkg::*; #(
  parameter int unsigned MAX_BUCKETS  = 512,
  parameter int unsigned POOL_ENTRIES = 1024
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  chm_req_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output chm_rsp_t         out_data,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_data
);

  logic [CFG_W-1:0] bucket_count_r;
  chm_cmd_t cmd;
  chm_sts_t sts;

  always_ff @(posedge clk) begin
    if (!rst_n) bucket_count_r <= BUCKETS_RESET;
    else if (cfg_we) bucket_count_r <= cfg_data;
  end

  chm_datapath #(
    .MAX_BUCKETS(MAX_BUCKETS), .POOL_ENTRIES(POOL_ENTRIES)
  ) u_dp (
    .clk, .rst_n, .bucket_count(bucket_count_r),
    .in_mode(in_data.mode), .in_key(in_data.key), .in_value(in_data.value),
    .cmd, .sts, .res(out_data)
  );

  chm_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready,
    .sts, .cmd
  );

endmodule

@@ tb/sv/tb.sv @@
// self-checking testbench for the chained hash map
module tb import chm_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NBUCKET = 512;
  localparam int unsigned NPOOL   = 1024;
  localparam int unsigned CHAIN_END = NPOOL;
  localparam int unsigned CYCLE_LIMIT = 20000000;

  typedef struct {
    status_t     status;
    logic [31:0] old_value;
    logic [10:0] entry_count;
  } reply_t;

  typedef struct {
    mode_t       mode;
    logic [31:0] key;
    logic [31:0] value;
    bit          typed;
    reply_t      reply;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  chm_req_t    in_data;
  logic        out_valid;
  logic        out_ready;
  chm_rsp_t    out_data;
  logic        cfg_we;
  logic [CFG_W-1:0] cfg_data;

  chained_hash_map i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  // map shadow
  int unsigned heads [NBUCKET];
  logic [31:0] slot_key [NPOOL];
  logic [31:0] slot_value [NPOOL];
  int unsigned slot_link [NPOOL];
  int unsigned free_head, fresh_mark, stored;
  logic [CFG_W-1:0] bucket_reg;

  reply_t      expected_q [$];
  int          errors = 0;
  bit          quiet;
  int unsigned cycles = 0;
  int unsigned stall_left;
  logic [31:0] fill_keys [NPOOL + 8];
  logic [31:0] key_pool [16];
  stim_row_t   rows [25];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic reply_t map_step(mode_t m, logic [31:0] k, logic [31:0] v);
    reply_t r;
    int unsigned nb, b, prev, cur, steps, e;
    bit found;
    r.status = ST_ABSENT;
    r.old_value = '0;
    if (k == '0) begin
      r.status = ST_ZERO_KEY;
    end else begin
      nb = (bucket_reg == 0) ? 1 : (bucket_reg > NBUCKET) ? NBUCKET : bucket_reg;
      b = (k >> 2) % nb;
      prev = CHAIN_END;
      cur = heads[b];
      steps = 0;
      found = 1'b0;
      while (cur < CHAIN_END && steps < NPOOL) begin
        if (slot_key[cur] == k) begin
          found = 1'b1;
          break;
        end
        prev = cur;
        cur = slot_link[cur];
        steps++;
      end
      if (m == MODE_PUT) begin
        if (found) begin
          r.old_value = slot_value[cur];
          slot_value[cur] = v;
          r.status = ST_FOUND;
        end else begin
          e = CHAIN_END;
          if (stored < fresh_mark && free_head < CHAIN_END) begin
            e = free_head;
            free_head = slot_link[e];
          end else if (stored >= fresh_mark && fresh_mark < CHAIN_END) begin
            e = fresh_mark;
            fresh_mark++;
          end
          if (e < CHAIN_END) begin
            slot_key[e] = k;
            slot_value[e] = v;
            slot_link[e] = heads[b];
            heads[b] = e;
            stored++;
          end else begin
            r.status = ST_POOL_FULL;
          end
        end
      end else if (m == MODE_REMOVE) begin
        if (found) begin
          r.old_value = slot_value[cur];
          if (prev < CHAIN_END) slot_link[prev] = slot_link[cur];
          else heads[b] = slot_link[cur];
          slot_link[cur] = free_head;
          free_head = cur;
          if (stored > 0) stored--;
          r.status = ST_FOUND;
        end
      end else if (found) begin
        r.old_value = slot_value[cur];
        r.status = ST_FOUND;
      end
    end
    r.entry_count = stored[10:0];
    return r;
  endfunction

  task automatic send_request(mode_t m, logic [31:0] k, logic [31:0] v,
                              bit typed, reply_t typed_reply);
    int gap;
    reply_t r;
    gap = quiet ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    r = map_step(m, k, v);
    expected_q.push_back(typed ? typed_reply : r);
    in_valid <= 1'b1;
    in_data  <= '{mode: m, key: k, value: v};
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_pred(mode_t m, logic [31:0] k, logic [31:0] v);
    reply_t none;
    none = '{ST_ABSENT, '0, '0};
    send_request(m, k, v, 1'b0, none);
  endtask

  task automatic set_buckets(logic [CFG_W-1:0] n);
    in_valid <= 1'b0;
    @(posedge clk);
    wait (expected_q.size() == 0);
    repeat (120) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= n;
    @(posedge clk);
    cfg_we <= 1'b0;
    bucket_reg = n;
  endtask

  function automatic mode_t pick_mode();
    int unsigned r;
    r = $urandom_range(0, 9);
    return (r < 3) ? MODE_GET : (r < 6) ? MODE_PUT : (r < 9) ? MODE_REMOVE : MODE_SPARE;
  endfunction

  // result checker and receiver stalls
  always @(posedge clk) begin
    reply_t e;
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result status %0d old %h count %0d", $time,
                   out_data.status, out_data.old_value, out_data.entry_count);
          errors++;
        end else begin
          e = expected_q.pop_front();
          if (out_data.status !== e.status) begin
            $display("%0t: status expected %0d actual %0d", $time, e.status,
                     out_data.status);
            errors++;
          end
          if (out_data.old_value !== e.old_value) begin
            $display("%0t: old_value expected %h actual %h", $time, e.old_value,
                     out_data.old_value);
            errors++;
          end
          if (out_data.entry_count !== e.entry_count) begin
            $display("%0t: entry_count expected %0d actual %0d", $time, e.entry_count,
                     out_data.entry_count);
            errors++;
          end
        end
        stall_left = quiet ? 0 : $urandom_range(0, 16);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_ready <= (stall_left == 0);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("chained_hash_map regression: fail");
      $finish;
    end
  end

  initial begin
    int unsigned nfill, i, j;
    logic [CFG_W-1:0] settings [7];
    logic [31:0] k;
    quiet = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '{mode: MODE_GET, key: '0, value: '0};
    cfg_we = 1'b0;
    cfg_data = '0;
    bucket_reg = BUCKETS_RESET;
    foreach (heads[b]) heads[b] = CHAIN_END;
    foreach (slot_key[s]) begin
      slot_key[s] = '0;
      slot_value[s] = '0;
      slot_link[s] = 0;
    end
    free_head = 0;
    fresh_mark = 0;
    stored = 0;

    rows = '{
      '{MODE_GET,    32'h1,        32'h0,        1'b1, '{ST_ABSENT,    32'h0, 11'd0}},
      '{MODE_PUT,    32'h0,        32'h5,        1'b1, '{ST_ZERO_KEY,  32'h0, 11'd0}},
      '{MODE_GET,    32'h0,        32'h0,        1'b1, '{ST_ZERO_KEY,  32'h0, 11'd0}},
      '{MODE_REMOVE, 32'h0,        32'h0,        1'b1, '{ST_ZERO_KEY,  32'h0, 11'd0}},
      '{MODE_PUT,    32'hffffffff, 32'hffffffff, 1'b1, '{ST_ABSENT,    32'h0, 11'd1}},
      '{MODE_GET,    32'hffffffff, 32'h0,        1'b1,
        '{ST_FOUND, 32'hffffffff, 11'd1}},
      '{MODE_PUT,    32'hffffffff, 32'h0,        1'b1,
        '{ST_FOUND, 32'hffffffff, 11'd1}},
      '{MODE_SPARE,  32'hffffffff, 32'h1234,     1'b1, '{ST_FOUND,     32'h0, 11'd1}},
      '{MODE_REMOVE, 32'hffffffff, 32'h0,        1'b1, '{ST_FOUND,     32'h0, 11'd0}},
      '{MODE_REMOVE, 32'hffffffff, 32'h0,        1'b1, '{ST_ABSENT,    32'h0, 11'd0}},
      '{MODE_PUT,    32'h1,        32'ha5a5a5a5, 1'b1, '{ST_ABSENT,    32'h0, 11'd1}},
      '{MODE_PUT,    32'h2,        32'h5a5a5a5a, 1'b0, '{ST_ABSENT,    32'h0, 11'd0}},
      '{MODE_PUT,    32'h3,        32'h1,        1'b0, '{ST_ABSENT,    32'h0, 11'd0}},
      '{MODE_PUT,    32'h7f0,      32'h80000000, 1'b0, '{ST_ABSENT,    32'h0, 11'd0}},
      '{MODE_PUT,    32'h80000000, 32'h7fffffff, 1'b0, '{ST_ABSENT,    32'h0, 11'd0}},
      '{MODE_REMOVE, 32'h2,        32'h0,        1'b0, '{ST_ABSENT,    32'h0, 11'd0}},
      '{MODE_GET,    32'h3,        32'h0,        1'b0, '{ST_ABSENT,    32'h0, 11'd0}},
      '{MODE_GET,    32'h2,        32'h0,        1'b0, '{ST_ABSENT,    32'h0, 11'd0}},
      '{MODE_REMOVE, 32'h1,        32'h0,        1'b0, '{ST_ABSENT,    32'h0, 11'd0}},
      '{MODE_REMOVE, 32'h3,        32'h0,        1'b0, '{ST_ABSENT,    32'h0, 11'd0}},
      '{MODE_PUT,    32'h2,        32'hdeadbeef, 1'b0, '{ST_ABSENT,    32'h0, 11'd0}},
      '{MODE_GET,    32'h7f0,      32'h0,        1'b0, '{ST_ABSENT,    32'h0, 11'd0}},
      '{MODE_REMOVE, 32'h80000000, 32'h0,        1'b0, '{ST_ABSENT,    32'h0, 11'd0}},
      '{MODE_PUT,    32'h80000001, 32'h3,        1'b0, '{ST_ABSENT,    32'h0, 11'd0}},
      '{MODE_SPARE,  32'h2,        32'h0,        1'b0, '{ST_ABSENT,    32'h0, 11'd0}}
    };

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (rows[r]) begin
      send_request(rows[r].mode, rows[r].key, rows[r].value, rows[r].typed,
                   rows[r].reply);
    end

    // fill the pool with distinct keys until it overflows
    set_buckets(10'd512);
    nfill = NPOOL + 4;
    for (i = 0; i < nfill; i++) begin
      fill_keys[i] = {i[19:0] + 20'd1, 12'($urandom_range(0, 4095))};
      if (i % 100 == 0) quiet = ($urandom_range(0, 3) == 0);
      send_pred(MODE_PUT, fill_keys[i], $urandom);
    end

    // mixed traffic on a nearly full pool
    for (i = 0; i < 300; i++) begin
      if (i % 60 == 0) quiet = ($urandom_range(0, 3) == 0);
      k = ($urandom_range(0, 4) == 0) ? $urandom : fill_keys[$urandom_range(0, nfill - 1)];
      send_pred(pick_mode(), k, $urandom);
    end

    settings = '{10'd1, 10'd0, 10'd1023, 10'd2, 10'd513,
                 10'($urandom_range(3, 511)), 10'd509};
    foreach (settings[s]) begin
      set_buckets(settings[s]);
      quiet = 1'b0;
      for (j = 0; j < 16; j++)
        key_pool[j] = (j < 6) ? 32'(j + 1) : (j < 8) ? (32'hffffffff - j) : $urandom;
      for (i = 0; i < 55; i++) begin
        if (i == 30) quiet = 1'b1;
        if (i == 45) quiet = 1'b0;
        case ($urandom_range(0, 19))
          0:       k = '0;
          1, 2:    k = fill_keys[$urandom_range(0, nfill - 1)];
          3:       k = $urandom;
          default: k = key_pool[$urandom_range(0, 15)];
        endcase
        send_pred(pick_mode(), k, $urandom);
      end
    end

    in_valid <= 1'b0;
    quiet = 1'b0;
    wait (expected_q.size() == 0);
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("chained_hash_map regression: pass");
    end else begin
      $display("chained_hash_map regression: fail");
    end
    $finish;
  end

endmodule

@@ chained_hash_map.f @@
sv/chm_pkg.sv
sv/chm_datapath.sv
sv/chm_ctrl.sv
sv/chained_hash_map.sv
tb/sv/tb.sv
